// File: rtl/s2d_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package s2d_pkg;

    localparam int MAG_W       = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIGIT_CNT_W = 5;
    localparam int BIT_CNT_W   = 6;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic trim;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic neg;
    } t_dp_status;

endpackage

// File: rtl/s2d_dp.sv
// Datapath: magnitude and BCD shift registers, digit counter, output character register.
module s2d_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [63:0]           i_number,
    input  s2d_pkg::t_dp_cmd      i_cmd,
    output s2d_pkg::t_dp_status   o_status,
    output logic [7:0]            o_ascii_char,
    output logic                  o_last_char
);

    localparam logic [s2d_pkg::BIT_CNT_W-1:0] LAST_BIT =
        s2d_pkg::BIT_CNT_W'(s2d_pkg::MAG_W - 1);

    logic [s2d_pkg::MAG_W-1:0]       r_mag;
    logic [s2d_pkg::BCD_W-1:0]       r_bcd;
    logic                            r_neg;
    logic [s2d_pkg::DIGIT_CNT_W-1:0] r_cnt;
    logic [s2d_pkg::BIT_CNT_W-1:0]   r_bit;
    logic [7:0]                      r_char;
    logic                            r_last;

    logic [s2d_pkg::BCD_W-1:0]       n_bcd_adj;
    logic [3:0]                      top_digit;

    // Add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < s2d_pkg::NUM_DIGITS; k++) begin
            d = r_bcd[4*k +: 4];
            n_bcd_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign top_digit = r_bcd[s2d_pkg::BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg <= 1'b0;
            r_cnt <= '0;
            r_bit <= '0;
        end else begin
            if (i_cmd.load) begin
                r_neg <= i_number[63];
                r_mag <= i_number[63] ? (64'd0 - i_number) : i_number;
                r_bcd <= '0;
                r_cnt <= s2d_pkg::DIGIT_CNT_W'(s2d_pkg::NUM_DIGITS);
                r_bit <= '0;
            end else if (i_cmd.conv_step) begin
                r_bcd <= {n_bcd_adj[s2d_pkg::BCD_W-2:0], r_mag[s2d_pkg::MAG_W-1]};
                r_mag <= {r_mag[s2d_pkg::MAG_W-2:0], 1'b0};
                r_bit <= r_bit + 1'b1;
            end else if (i_cmd.trim || i_cmd.emit_digit) begin
                r_bcd <= {r_bcd[s2d_pkg::BCD_W-5:0], 4'd0};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= s2d_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= s2d_pkg::CHAR_ZERO + {4'd0, top_digit};
            r_last <= (r_cnt == s2d_pkg::DIGIT_CNT_W'(1));
        end
    end

    assign o_status.conv_done = (r_bit == LAST_BIT);
    assign o_status.top_zero  = (top_digit == 4'd0);
    assign o_status.one_left  = (r_cnt == s2d_pkg::DIGIT_CNT_W'(1));
    assign o_status.neg       = r_neg;
    assign o_ascii_char       = r_char;
    assign o_last_char        = r_last;

endmodule

// File: rtl/s2d_ctrl.sv
// Controller: sequences conversion, leading-zero trim and character output.
module s2d_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  s2d_pkg::t_dp_status   i_status,
    output s2d_pkg::t_dp_cmd      o_cmd
);

    s2d_pkg::t_state r_state, n_state;
    logic            r_ovalid, n_ovalid;
    logic            slot_free;

    assign slot_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= s2d_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            s2d_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = s2d_pkg::ST_CONV;
                end
            end
            s2d_pkg::ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = s2d_pkg::ST_TRIM;
                end
            end
            s2d_pkg::ST_TRIM: begin
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.trim = 1'b1;
                end else begin
                    n_state = s2d_pkg::ST_SIGN;
                end
            end
            s2d_pkg::ST_SIGN: begin
                if (!i_status.neg) begin
                    n_state = s2d_pkg::ST_DIGITS;
                end else if (slot_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = s2d_pkg::ST_DIGITS;
                end
            end
            s2d_pkg::ST_DIGITS: begin
                if (slot_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.one_left) begin
                        n_state = s2d_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = s2d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit_sign || o_cmd.emit_digit) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// File: rtl/signed_int_to_decimal_ascii_top.sv
// Sequence: take a number, run the double-dabble shift loop (one magnitude bit per cycle),
// drop leading zero digits one at a time, emit the sign when negative, then move each
// character into the output register as the output slot frees up.
// A new number is taken only after the last character of the previous one is in the output
// register (each of the 20 digit positions is either dropped or sent); receiver stalls delay it.
// Reset (synchronous, active low) returns the controller to idle and empties the output register.
module signed_int_to_decimal_ascii_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Number input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_number,
    // Character output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_ascii_char,
    output logic        o_last_char
);

    // Commands from the controller, status back from the datapath
    s2d_pkg::t_dp_cmd    cmd;
    s2d_pkg::t_dp_status status;

    // Controller: takes a transfer when idle, steps the shift loop, trims leading zeros,
    // and releases each character only when the output register is free or being drained.
    s2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: the magnitude (with the most negative value becoming 2^63) shifts into
    // a 20-digit BCD register; digits then leave from the top, four bits at a time.
    s2d_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_number     (i_number),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

// File: bench/signed_int_to_decimal_ascii_top_test.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus sizes and run limits
    localparam int NUM_RANDOM     = 450;
    localparam int MAX_GAP        = 14;
    localparam int HOLD_AFTER     = 150;   // numbers taken before the long receiver hold-off
    localparam int HOLD_CYCLES    = 1200;  // length of that hold-off
    localparam int DRAIN_CYCLES   = 200;   // quiet time after the last character
    localparam int WATCHDOG_LIMIT = 8000;  // cycles without any transfer before giving up
    localparam logic [63:0] RADIX = 64'd10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_decimal_char;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_number = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_ascii_char;
    logic        o_last_char;

    logic [63:0]   pending_numbers[$];   // numbers not yet offered to the block
    t_decimal_char expected_text[$];     // characters predicted but not yet seen

    int error_count   = 0;
    int numbers_taken = 0;
    int send_wait     = 0;
    int calm_tx       = 0;
    int recv_wait     = 0;
    int calm_rx       = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int idle_cycles   = 0;

    signed_int_to_decimal_ascii_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

    always #2 i_clk = ~i_clk;

    // Append the decimal text of one number to the expected characters.
    // The magnitude is taken as unsigned, so the most negative value maps to 2^63.
    function automatic void push_decimal_text(input logic [63:0] number);
        logic [63:0]   mag;
        logic [7:0]    digits[s2d_pkg::NUM_DIGITS];
        int            count;
        t_decimal_char entry;
        mag   = number[63] ? (64'd0 - number) : number;
        count = 0;
        do begin
            digits[count] = s2d_pkg::CHAR_ZERO + 8'(mag % RADIX);
            mag           = mag / RADIX;
            count++;
        end while (mag != 64'd0 && count < s2d_pkg::NUM_DIGITS);
        if (number[63]) begin
            entry.ch   = s2d_pkg::CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        for (int i = count - 1; i >= 0; i--) begin
            entry.ch   = digits[i];
            entry.last = (i == 0);
            expected_text.push_back(entry);
        end
    endfunction

    // Draw a random number, spread over all lengths of decimal text.
    function automatic logic [63:0] random_number();
        logic [63:0] value;
        logic [63:0] pow10;
        int          kind;
        kind  = $urandom_range(0, 9);
        value = {$urandom, $urandom};
        pow10 = 64'd1;
        if (kind >= 3 && kind < 8) begin
            // short and medium magnitudes
            value = value >> $urandom_range(0, 63);
        end else if (kind >= 8) begin
            // near a power of ten: digit count changes here
            repeat ($urandom_range(0, 18)) pow10 = pow10 * RADIX;
            value = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
        end
        if (kind >= 3 && $urandom_range(0, 1) == 1)
            value = 64'd0 - value;
        return value;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        error_count++;
    endtask

    // Sender: offer the next pending number, then idle a drawn number of cycles
    // after its transfer. Runs of zero gaps come in calm stretches.
    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            taken = i_valid && o_ready;
            if (taken) begin
                push_decimal_text(i_number);
                numbers_taken++;
            end
            // hold valid and payload until the transfer
            if (!i_valid || taken) begin
                if (send_wait != 0) begin
                    i_valid   <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_numbers.size() != 0) begin
                    i_valid  <= 1'b1;
                    i_number <= pending_numbers.pop_front();
                    if (calm_tx > 0) begin
                        send_wait <= 0;
                        calm_tx   <= calm_tx - 1;
                    end else begin
                        send_wait <= $urandom_range(0, MAX_GAP);
                        if ($urandom_range(0, 29) == 0)
                            calm_tx <= $urandom_range(10, 40);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here: the sender keeps offering numbers,
    // so the block fills up and must drop o_ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && numbers_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: check each character transfer against the oldest expectation,
    // then stall a drawn number of cycles before taking the next one.
    always @(posedge i_clk) begin
        t_decimal_char want;
        int            gap;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              o_ascii_char, o_last_char));
                end else begin
                    want = expected_text.pop_front();
                    if (o_ascii_char !== want.ch)
                        report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                                  o_ascii_char, want.ch));
                    if (o_last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, expected %0b",
                                                  o_last_char, want.last));
                end
            end
            // at most one assignment to i_ready per edge
            if (hold_left > 0) begin
                i_ready <= 1'b0;
            end else if (o_valid && i_ready) begin
                if (calm_rx > 0) begin
                    gap = 0;
                    calm_rx <= calm_rx - 1;
                end else begin
                    gap = $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 29) == 0)
                        calm_rx <= $urandom_range(10, 60);
                end
                if (gap == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready   <= 1'b0;
                    recv_wait <= gap - 1;
                end
            end else if (!i_ready) begin
                if (recv_wait == 0)
                    i_ready <= 1'b1;
                else
                    recv_wait <= recv_wait - 1;
            end
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("signed_int_to_decimal_ascii_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed numbers: zero, single digits, digit-count edges, the
        // largest and most negative values, and alternating bit patterns.
        pending_numbers.push_back(64'd0);
        pending_numbers.push_back(64'd1);
        pending_numbers.push_back(-64'sd1);
        pending_numbers.push_back(64'd9);
        pending_numbers.push_back(64'd10);
        pending_numbers.push_back(-64'sd10);
        pending_numbers.push_back(64'd99);
        pending_numbers.push_back(64'd100);
        pending_numbers.push_back(64'd999999999999);
        pending_numbers.push_back(64'd1000000000000);
        pending_numbers.push_back(-64'sd1000000000000);
        pending_numbers.push_back(64'd999999999999999999);
        pending_numbers.push_back(64'd1000000000000000000);
        pending_numbers.push_back(-64'sd1000000000000000000);
        pending_numbers.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_numbers.push_back(64'h8000_0000_0000_0000);
        pending_numbers.push_back(64'h8000_0000_0000_0001);
        pending_numbers.push_back(64'h5555_5555_5555_5555);
        pending_numbers.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_numbers.push_back(64'd123456789);
        pending_numbers.push_back(-64'sd7);
        pending_numbers.push_back(64'd0);
        for (int n = 0; n < NUM_RANDOM; n++)
            pending_numbers.push_back(random_number());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge, once all transfer bookkeeping has settled.
        while (pending_numbers.size() != 0 || i_valid || expected_text.size() != 0)
            @(negedge i_clk);
        // Let any stray characters show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii_top: match");
        end else begin
            $display("signed_int_to_decimal_ascii_top: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/s2d_pkg.sv
rtl/s2d_dp.sv
rtl/s2d_ctrl.sv
rtl/signed_int_to_decimal_ascii_top.sv
bench/signed_int_to_decimal_ascii_top_test.sv
